[sv/gms_pkg.sv]
`timescale 1ns / 1ps
// gms_pkg: shared constants, register codes and item flag type for the morphology block
// no dependencies
package gms_pkg;

    localparam int DEF_MAX_RADIUS = 3;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int ROW_BITS     = 13;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int RAD_BITS     = 2;
    localparam int CFG_W_BITS   = 11;
    localparam int CFG_H_BITS   = 13;
    localparam int OUT_X_BITS   = 10;
    localparam int OUT_Y_BITS   = 12;
    localparam int ADDR_BITS    = 4;
    localparam int DATA_BITS    = 32;

    localparam logic [CFG_W_BITS-1:0] RESET_WIDTH  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] RESET_HEIGHT = 13'd1024;
    localparam logic [RAD_BITS-1:0]   RESET_RADIUS = 2'd1;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_RADIUS = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic has_out;
        logic last;
        logic clr;
    } item_flags_t;

endpackage

[sv/gms_ctrl.sv]
`timescale 1ns / 1ps
// gms_ctrl: raster counters, frame bookkeeping and output lag check per accepted word
// depends on gms_pkg
module gms_ctrl #(
    parameter int MAX_RADIUS = gms_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = gms_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = gms_pkg::DEF_PIXEL_BITS,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int WW         = $clog2(MAX_WIDTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          kind,
    input  logic [PIXEL_BITS-1:0]         pixel_in,
    input  logic [gms_pkg::RAD_BITS-1:0]  window_radius,
    input  logic [gms_pkg::CFG_W_BITS-1:0] image_width,
    input  logic [gms_pkg::CFG_H_BITS-1:0] image_height,
    output logic [WW-1:0]                 width_eff,
    output logic [gms_pkg::ROW_BITS-1:0]  height_eff,
    output logic [gms_pkg::RAD_BITS-1:0]  radius_eff,
    output logic                          push,
    output logic [CW-1:0]                 col,
    output logic [gms_pkg::ROW_BITS-1:0]  row,
    output logic [PIXEL_BITS-1:0]         sample,
    output logic [CW-1:0]                 ox,
    output logic [gms_pkg::ROW_BITS-1:0]  oy,
    output gms_pkg::item_flags_t          flags
);
    import gms_pkg::*;

    localparam int PW = ROW_BITS + WW;

    logic [CW-1:0]       in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_BITS-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic                pend_reg, pend_next;
    logic [CW-1:0]       in_col0, out_col0, in_col1, out_col1;
    logic [ROW_BITS-1:0] in_row0, out_row0, in_row1, out_row1;
    logic                nf_start, in_frame, has_out, last;
    logic [PW-1:0]       pos, lag;

    // effective configuration
    always_comb
    begin
        if (image_width == '0)
            width_eff = WW'(1);
        else if (32'(image_width) > MAX_WIDTH)
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(image_width);
        if (image_height == '0)
            height_eff = ROW_BITS'(1);
        else if (32'(image_height) > HEIGHT_LIMIT)
            height_eff = ROW_BITS'(HEIGHT_LIMIT);
        else
            height_eff = ROW_BITS'(image_height);
        if (32'(window_radius) > MAX_RADIUS)
            radius_eff = RAD_BITS'(MAX_RADIUS);
        else
            radius_eff = window_radius;
    end

    // wrap, frame restart and lag
    always_comb
    begin
        if (WW'(in_col_reg) >= width_eff)
        begin
            in_col0 = '0;
            in_row0 = in_row_reg + 1'b1;
        end
        else
        begin
            in_col0 = in_col_reg;
            in_row0 = in_row_reg;
        end
        if (WW'(out_col_reg) >= width_eff)
        begin
            out_col0 = '0;
            out_row0 = out_row_reg + 1'b1;
        end
        else
        begin
            out_col0 = out_col_reg;
            out_row0 = out_row_reg;
        end
        nf_start = (out_row0 >= height_eff);
        if (nf_start)
        begin
            in_col0  = '0;
            in_row0  = '0;
            out_col0 = '0;
            out_row0 = '0;
        end
        in_frame = (in_row0 < height_eff);
        push     = !(in_frame && kind);
        sample   = in_frame ? pixel_in : '0;
        pos      = PW'(in_row0) * PW'(width_eff) + PW'(in_col0);
        lag      = PW'(radius_eff) * PW'(width_eff) + PW'(radius_eff);
        has_out  = (pos >= lag);
        last     = (WW'(out_col0) == width_eff - 1'b1) && (out_row0 == height_eff - 1'b1);
        if (WW'(in_col0) + WW'(1) >= width_eff)
        begin
            in_col1 = '0;
            in_row1 = in_row0 + 1'b1;
        end
        else
        begin
            in_col1 = in_col0 + CW'(1);
            in_row1 = in_row0;
        end
        if (WW'(out_col0) + WW'(1) >= width_eff)
        begin
            out_col1 = '0;
            out_row1 = out_row0 + 1'b1;
        end
        else
        begin
            out_col1 = out_col0 + CW'(1);
            out_row1 = out_row0;
        end
    end

    assign col   = in_col0;
    assign row   = in_row0;
    assign ox    = out_col0;
    assign oy    = out_row0;
    assign flags = '{has_out: has_out, last: has_out && last, clr: pend_reg || nf_start};

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        if (accept)
        begin
            pend_next = push ? (has_out && last) : (pend_reg || nf_start);
            if (push)
            begin
                in_col_next = in_col1;
                in_row_next = in_row1;
            end
            else
            begin
                in_col_next = in_col0;
                in_row_next = in_row0;
            end
            if (push && has_out)
            begin
                out_col_next = out_col1;
                out_row_next = out_row1;
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end
            else
            begin
                out_col_next = out_col0;
                out_row_next = out_row0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

[sv/gms_line.sv]
`timescale 1ns / 1ps
// gms_line: line store memory with read-modify-write and forwarding, and the column window
// depends on gms_pkg
module gms_line #(
    parameter int MAX_RADIUS = gms_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = gms_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = gms_pkg::DEF_PIXEL_BITS,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int WS         = 2 * MAX_RADIUS + 1,
    parameter int TB         = gms_pkg::ROW_BITS + 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic [CW-1:0]                       col,
    input  logic [gms_pkg::ROW_BITS-1:0]        row,
    input  logic [PIXEL_BITS-1:0]               sample,
    input  logic [gms_pkg::RAD_BITS-1:0]        radius,
    input  logic [CW-1:0]                       ox,
    input  logic [gms_pkg::ROW_BITS-1:0]        oy,
    input  gms_pkg::item_flags_t                flags,
    input  logic                                dn_ready,
    output logic                                up_ready,
    output logic                                s2_valid,
    output logic [CW-1:0]                       s2_ox,
    output logic [gms_pkg::ROW_BITS-1:0]        s2_oy,
    output logic [gms_pkg::RAD_BITS-1:0]        s2_radius,
    output gms_pkg::item_flags_t                s2_flags,
    output logic [WS-1:0][WS-1:0][PIXEL_BITS-1:0] win_pix,
    output logic [WS-1:0][CW-1:0]               win_col,
    output logic [WS-1:0][TB-1:0]               win_top,
    output logic [WS-1:0]                       win_full
);
    import gms_pkg::*;

    localparam int LN = 2 * MAX_RADIUS;
    localparam int LB = LN * PIXEL_BITS;

    logic [LB-1:0]         mem [MAX_WIDTH];
    logic [LB-1:0]         mem_q_reg, fwd_data_reg, line_q, new_line;
    logic                  fwd_sel_reg;
    logic                  v1_reg, v1_next, v2_reg, v2_next;
    logic                  move12, move23;
    logic [CW-1:0]         x1_reg, ox1_reg;
    logic [ROW_BITS-1:0]   y1_reg, oy1_reg;
    logic [PIXEL_BITS-1:0] val1_reg;
    logic [RAD_BITS-1:0]   rad1_reg;
    item_flags_t           fl1_reg;
    logic [WS-1:0][PIXEL_BITS-1:0] vec;

    assign move23   = v2_reg && dn_ready;
    assign move12   = v1_reg && (!v2_reg || dn_ready);
    assign up_ready = !v1_reg || move12;
    assign s2_valid = v2_reg;

    assign v1_next = load ? 1'b1 : (move12 ? 1'b0 : v1_reg);
    assign v2_next = move12 ? 1'b1 : (move23 ? 1'b0 : v2_reg);

    // new column and shifted line history
    always_comb
    begin
        line_q = fwd_sel_reg ? fwd_data_reg : mem_q_reg;
        for (int k = 0; k < WS; k++)
            vec[k] = '0;
        for (int k = 0; k < LN; k++)
            if (k < 2 * int'(rad1_reg))
                vec[k] = line_q[k*PIXEL_BITS +: PIXEL_BITS];
        for (int k = 0; k < WS; k++)
            if (k == 2 * int'(rad1_reg))
                vec[k] = val1_reg;
        for (int k = 0; k < LN; k++)
            new_line[k*PIXEL_BITS +: PIXEL_BITS] = (k < 2 * int'(rad1_reg)) ?
                vec[k+1] : line_q[k*PIXEL_BITS +: PIXEL_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (move12)
            mem[x1_reg] <= new_line;
        if (load)
        begin
            mem_q_reg    <= mem[col];
            fwd_sel_reg  <= move12 && (x1_reg == col);
            fwd_data_reg <= new_line;
            x1_reg       <= col;
            y1_reg       <= row;
            val1_reg     <= sample;
            rad1_reg     <= radius;
            ox1_reg      <= ox;
            oy1_reg      <= oy;
            fl1_reg      <= flags;
        end
        if (move12)
        begin
            s2_ox     <= ox1_reg;
            s2_oy     <= oy1_reg;
            s2_radius <= rad1_reg;
            s2_flags  <= fl1_reg;
            for (int c = 0; c < WS - 1; c++)
            begin
                win_pix[c] <= win_pix[c+1];
                win_col[c] <= win_col[c+1];
                win_top[c] <= win_top[c+1];
            end
            win_pix[WS-1] <= vec;
            win_col[WS-1] <= x1_reg;
            win_top[WS-1] <= TB'(y1_reg) - TB'({rad1_reg, 1'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            win_full <= '0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            if (move12)
            begin
                for (int c = 0; c < WS - 1; c++)
                    win_full[c] <= win_full[c+1] && !fl1_reg.clr;
                win_full[WS-1] <= 1'b1;
            end
        end
    end

endmodule

[sv/gms_reduce.sv]
`timescale 1ns / 1ps
// gms_reduce: clipped window extreme, with a registered per-column stage feeding the output register
// depends on gms_pkg
module gms_reduce #(
    parameter int MAX_RADIUS = gms_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = gms_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = gms_pkg::DEF_PIXEL_BITS,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int WS         = 2 * MAX_RADIUS + 1,
    parameter int TB         = gms_pkg::ROW_BITS + 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                erode,
    input  logic [WW-1:0]                       width_eff,
    input  logic [gms_pkg::ROW_BITS-1:0]        height_eff,
    input  logic                                s2_valid,
    input  logic [CW-1:0]                       s2_ox,
    input  logic [gms_pkg::ROW_BITS-1:0]        s2_oy,
    input  logic [gms_pkg::RAD_BITS-1:0]        s2_radius,
    input  gms_pkg::item_flags_t                s2_flags,
    input  logic [WS-1:0][WS-1:0][PIXEL_BITS-1:0] win_pix,
    input  logic [WS-1:0][CW-1:0]               win_col,
    input  logic [WS-1:0][TB-1:0]               win_top,
    input  logic [WS-1:0]                       win_full,
    output logic                                dn_ready,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [PIXEL_BITS-1:0]               pixel_out,
    output logic [gms_pkg::OUT_X_BITS-1:0]      out_x,
    output logic [gms_pkg::OUT_Y_BITS-1:0]      out_y,
    output logic                                frame_last
);
    import gms_pkg::*;

    logic                  v3_reg, v3_next, v4_reg, v4_next;
    logic                  move23, move34;
    logic [WS-1:0][PIXEL_BITS-1:0] colx, colx_reg;
    logic [CW-1:0]         ox3_reg, ox4_reg;
    logic [ROW_BITS-1:0]   oy3_reg, oy4_reg;
    logic                  has3_reg, last3_reg, last4_reg;
    logic [PIXEL_BITS-1:0] pix4_reg, ext, ident;

    assign move34   = v3_reg && (!v4_reg || out_ready);
    assign dn_ready = !v3_reg || move34;
    assign move23   = s2_valid && dn_ready;
    assign v3_next  = move23 ? 1'b1 : (move34 ? 1'b0 : v3_reg);
    assign v4_next  = (move34 && has3_reg) ? 1'b1 : ((v4_reg && out_ready) ? 1'b0 : v4_reg);
    assign ident    = erode ? '1 : '0;

    // per-column extreme over rows inside the clipped window
    always_comb
    begin
        logic [CW:0]           cx;
        logic signed [TB-1:0]  rw;
        logic                  col_ok, row_ok;
        for (int c = 0; c < WS; c++)
        begin
            cx = {1'b0, win_col[c]};
            col_ok = win_full[c] && (WW'(win_col[c]) < width_eff)
                     && (cx + (CW+1)'(s2_radius) >= {1'b0, s2_ox})
                     && (cx <= {1'b0, s2_ox} + (CW+1)'(s2_radius));
            colx[c] = ident;
            for (int r = 0; r < WS; r++)
            begin
                rw = $signed(win_top[c]) + $signed(TB'(r));
                row_ok = (rw >= 0) && (rw < $signed(TB'(height_eff)))
                         && (rw + $signed(TB'(s2_radius)) >= $signed(TB'(s2_oy)))
                         && (rw <= $signed(TB'(s2_oy)) + $signed(TB'(s2_radius)));
                if (col_ok && row_ok &&
                    (erode ? (win_pix[c][r] < colx[c]) : (win_pix[c][r] > colx[c])))
                    colx[c] = win_pix[c][r];
            end
        end
    end

    always_comb
    begin
        ext = ident;
        for (int c = 0; c < WS; c++)
            if (erode ? (colx_reg[c] < ext) : (colx_reg[c] > ext))
                ext = colx_reg[c];
    end

    always_ff @(posedge clk)
    begin
        if (move23)
        begin
            colx_reg  <= colx;
            ox3_reg   <= s2_ox;
            oy3_reg   <= s2_oy;
            has3_reg  <= s2_flags.has_out;
            last3_reg <= s2_flags.last;
        end
        if (move34 && has3_reg)
        begin
            pix4_reg  <= ext;
            ox4_reg   <= ox3_reg;
            oy4_reg   <= oy3_reg;
            last4_reg <= last3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign out_valid  = v4_reg;
    assign pixel_out  = pix4_reg;
    assign out_x      = OUT_X_BITS'(ox4_reg);
    assign out_y      = OUT_Y_BITS'(oy4_reg);
    assign frame_last = last4_reg;

endmodule

[sv/grayscale_morphology_square.sv]
`timescale 1ns / 1ps
// grayscale_morphology_square: streaming square-window dilation / erosion, top level
// word path: line read, window, column and output registers, once the raster lag is covered
// throughput: one word per cycle unless out_ready stalls, set by the line store's RMW port
// reset: rst_n clears counters, valid flags and window occupancy, registers take defaults
// the line store is not cleared; its entries are written before any output depends on them
// depends on gms_pkg, gms_ctrl, gms_line, gms_reduce
module grayscale_morphology_square #(
    parameter int MAX_RADIUS = gms_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = gms_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = gms_pkg::DEF_PIXEL_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [PIXEL_BITS-1:0]           pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [PIXEL_BITS-1:0]           pixel_out,
    output logic [gms_pkg::OUT_X_BITS-1:0]  out_x,
    output logic [gms_pkg::OUT_Y_BITS-1:0]  out_y,
    output logic                            frame_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gms_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [gms_pkg::DATA_BITS-1:0]   pwdata,
    output logic [gms_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready
);
    import gms_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int WS = 2 * MAX_RADIUS + 1;
    localparam int TB = ROW_BITS + 2;

    logic                  mode_reg;
    logic [RAD_BITS-1:0]   rad_reg;
    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    reg_idx_t              reg_idx;

    logic                  accept, push, load, dn_ready, s2_valid;
    logic [WW-1:0]         width_eff;
    logic [ROW_BITS-1:0]   height_eff, row, oy, s2_oy;
    logic [RAD_BITS-1:0]   radius_eff, s2_radius;
    logic [CW-1:0]         col, ox, s2_ox;
    logic [PIXEL_BITS-1:0] sample;
    item_flags_t           flags, s2_flags;
    logic [WS-1:0][WS-1:0][PIXEL_BITS-1:0] win_pix;
    logic [WS-1:0][CW-1:0] win_col;
    logic [WS-1:0][TB-1:0] win_top;
    logic [WS-1:0]         win_full;

    assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            rad_reg    <= RESET_RADIUS;
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_RADIUS: rad_reg    <= pwdata[RAD_BITS-1:0];
                REG_WIDTH:  width_reg  <= pwdata[CFG_W_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_H_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:   prdata = DATA_BITS'(mode_reg);
            REG_RADIUS: prdata = DATA_BITS'(rad_reg);
            REG_WIDTH:  prdata = DATA_BITS'(width_reg);
            REG_HEIGHT: prdata = DATA_BITS'(height_reg);
            default:    prdata = '0;
        endcase
    end

    assign accept = in_valid && in_ready;
    assign load   = accept && push;

    gms_ctrl #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW),
        .WW         (WW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .kind          (kind),
        .pixel_in      (pixel_in),
        .window_radius (rad_reg),
        .image_width   (width_reg),
        .image_height  (height_reg),
        .width_eff     (width_eff),
        .height_eff    (height_eff),
        .radius_eff    (radius_eff),
        .push          (push),
        .col           (col),
        .row           (row),
        .sample        (sample),
        .ox            (ox),
        .oy            (oy),
        .flags         (flags)
    );

    gms_line #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW),
        .WS         (WS),
        .TB         (TB)
    ) u_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .col       (col),
        .row       (row),
        .sample    (sample),
        .radius    (radius_eff),
        .ox        (ox),
        .oy        (oy),
        .flags     (flags),
        .dn_ready  (dn_ready),
        .up_ready  (in_ready),
        .s2_valid  (s2_valid),
        .s2_ox     (s2_ox),
        .s2_oy     (s2_oy),
        .s2_radius (s2_radius),
        .s2_flags  (s2_flags),
        .win_pix   (win_pix),
        .win_col   (win_col),
        .win_top   (win_top),
        .win_full  (win_full)
    );

    gms_reduce #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW),
        .WW         (WW),
        .WS         (WS),
        .TB         (TB)
    ) u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .erode      (mode_reg),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .s2_valid   (s2_valid),
        .s2_ox      (s2_ox),
        .s2_oy      (s2_oy),
        .s2_radius  (s2_radius),
        .s2_flags   (s2_flags),
        .win_pix    (win_pix),
        .win_col    (win_col),
        .win_top    (win_top),
        .win_full   (win_full),
        .dn_ready   (dn_ready),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .pixel_out  (pixel_out),
        .out_x      (out_x),
        .out_y      (out_y),
        .frame_last (frame_last)
    );

endmodule

[sv/gms_checker.sv]
`timescale 1ns / 1ps
// gms_checker: port-level checks for the morphology block, bound to the top level
// depends on gms_pkg and grayscale_morphology_square
module gms_checker #(
    parameter int PIXEL_BITS = gms_pkg::DEF_PIXEL_BITS
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [PIXEL_BITS-1:0]          pixel_out,
    input logic [gms_pkg::OUT_X_BITS-1:0] out_x,
    input logic [gms_pkg::OUT_Y_BITS-1:0] out_y,
    input logic                           frame_last,
    input logic                           pready
);
    import gms_pkg::*;

    // no result while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // empty output register never blocks the input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output register empty");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(out_x)
            && $stable(out_y) && $stable(frame_last))
        else $error("stalled output word changed");

    // register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind grayscale_morphology_square gms_checker #(.PIXEL_BITS(PIXEL_BITS)) u_gms_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .out_x      (out_x),
    .out_y      (out_y),
    .frame_last (frame_last),
    .pready     (pready)
);
